### rtl/tmfa_pkg.sv
// Package for the trimmed mean feedback angle block.
// Holds the fixed field widths, register indices and the structs passed between modules.
// It depends on nothing else.
`default_nettype none

package tmfa_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int ANGLE8_W  = 8;
    localparam int FILT_W    = 14;
    localparam int ANGLE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    localparam int DVD_W      = 20;
    localparam int DVS_W      = 10;
    localparam int DIV_CNT_W  = $clog2(DVD_W);

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_END     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ANGLE   = 2'd3;

    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

### rtl/trimmed_mean_feedback_angle.sv
// Trimmed mean of a set of NUM_SAMPLES readings, mapped onto a calibrated angle range.
// Samples are accepted one per cycle while the block is collecting. After the last transfer of a set
// the sorting chain is drained, three single steps filter, multiply and start the divider, the serial
// divider runs and the result goes into the result register; when the calibrated range is empty the
// divider is skipped. Samples are refused until then, and while a result waits.
// Reset clears the chain, the counters and the result valid flag and loads the default calibration.
`default_nettype none

module trimmed_mean_feedback_angle
#(
    parameter int NUM_SAMPLES = 12,
    parameter int DISCARD     = 2
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [tmfa_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [tmfa_pkg::CFG_DAT_W-1:0]    wr_data,
    input  wire logic                              in_valid,
    output      logic                              in_ready,
    input  wire logic [tmfa_pkg::SAMPLE_W-1:0]     sample,
    output      logic                              out_valid,
    input  wire logic                              out_ready,
    output      logic [tmfa_pkg::FILT_W-1:0]       filtered_value,
    output      logic signed [tmfa_pkg::ANGLE_W-1:0] angle,
    output      logic                              range_error,
    output      logic                              angle_saturated
);

    localparam int CNT_W    = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int SUM_W    = tmfa_pkg::SAMPLE_W + $clog2(NUM_SAMPLES + 1);
    localparam int KEPT     = NUM_SAMPLES - 2 * DISCARD;
    localparam int KEPT_DIV = (KEPT > 0) ? KEPT : 1;
    localparam int KEEP_LO  = DISCARD;
    localparam int KEEP_HI  = NUM_SAMPLES - DISCARD;
    localparam int SW       = tmfa_pkg::SAMPLE_W;
    localparam int WIDE_W   = 21;

    // The division by the kept count is a multiplication by its rounded-up reciprocal.
    localparam int     X_W    = SUM_W + 4;
    localparam int     REC_L  = $clog2(KEPT_DIV);
    localparam int     REC_SH = X_W + REC_L;
    localparam int     REC_W  = X_W + 1;
    localparam int     PROD_W = X_W + REC_W;
    localparam longint REC_M  =
        ((longint'(1) << REC_SH) + longint'(KEPT_DIV) - 1) / longint'(KEPT_DIV);

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_SAMPLES - 1);

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_DRAIN   = 3'd1;
    localparam logic [2:0] S_FILT    = 3'd2;
    localparam logic [2:0] S_MUL     = 3'd3;
    localparam logic [2:0] S_AGO     = 3'd4;
    localparam logic [2:0] S_AWAIT   = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [CNT_W-1:0]                  cnt_next;
    logic [SUM_W-1:0]                  sum_reg;
    logic [SUM_W-1:0]                  sum_next;

    logic [SW-1:0]                     low_end_reg;
    logic [SW-1:0]                     high_end_reg;
    logic [tmfa_pkg::ANGLE8_W-1:0]     start_angle_reg;
    logic [tmfa_pkg::ANGLE8_W-1:0]     end_angle_reg;

    logic [tmfa_pkg::FILT_W-1:0]       filt_reg;
    logic [tmfa_pkg::FILT_W-1:0]       filt_next;
    logic signed [19:0]                prod_reg;
    logic signed [19:0]                prod_next;
    logic signed [SW:0]                den_reg;
    logic signed [SW:0]                den_next;
    logic                              rerr_reg;
    logic                              rerr_next;
    logic signed [WIDE_W-1:0]          ang_reg;
    logic signed [WIDE_W-1:0]          ang_next;

    logic                              out_valid_reg;
    logic [tmfa_pkg::FILT_W-1:0]       filtered_value_reg;
    logic signed [tmfa_pkg::ANGLE_W-1:0] angle_reg;
    logic                              range_error_reg;
    logic                              angle_saturated_reg;

    tmfa_pkg::cell_ctrl_t              cell_ctrl;
    logic [SW-1:0]                     cell_val  [NUM_SAMPLES];
    logic [NUM_SAMPLES-1:0]            cell_full;
    logic [NUM_SAMPLES-1:0]            cell_gt;

    logic                              div_start;
    logic [tmfa_pkg::DVD_W-1:0]        div_dividend;
    logic [tmfa_pkg::DVS_W-1:0]        div_divisor;
    tmfa_pkg::div_stat_t               div_stat;
    logic [tmfa_pkg::DVD_W-1:0]        div_quo;

    logic                              in_xfer;
    logic                              out_free;
    logic                              keep_now;
    logic [PROD_W-1:0]                 rec_prod;
    logic [9:0]                        mean;
    logic signed [SW:0]                diff_w;
    logic signed [8:0]                 span_w;
    logic                              neg_w;
    logic signed [WIDE_W-1:0]          quo_signed;
    logic                              sat_hi;
    logic                              sat_lo;

    // Sorting chain: cell 0 holds the smallest sample.
    genvar gi;
    generate
        for (gi = 0; gi < NUM_SAMPLES; gi++)
        begin : g_cell
            logic          l_gt;
            logic [SW-1:0] l_val;
            logic          l_full;
            logic [SW-1:0] r_val;
            logic          r_full;
            if (gi == 0)
            begin : g_first
                assign l_gt   = 1'b0;
                assign l_val  = '0;
                assign l_full = 1'b0;
            end
            else
            begin : g_inner_l
                assign l_gt   = cell_gt[gi-1];
                assign l_val  = cell_val[gi-1];
                assign l_full = cell_full[gi-1];
            end
            if (gi == NUM_SAMPLES - 1)
            begin : g_last
                assign r_val  = '0;
                assign r_full = 1'b0;
            end
            else
            begin : g_inner_r
                assign r_val  = cell_val[gi+1];
                assign r_full = cell_full[gi+1];
            end
            tmfa_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .sample_in  (sample),
                .left_gt    (l_gt),
                .left_val   (l_val),
                .left_full  (l_full),
                .right_val  (r_val),
                .right_full (r_full),
                .val        (cell_val[gi]),
                .full       (cell_full[gi]),
                .gt         (cell_gt[gi])
            );
        end
    endgenerate

    tmfa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign in_ready  = (state_reg == S_COLLECT);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign cell_ctrl.insert = in_xfer;
    assign cell_ctrl.drain  = (state_reg == S_DRAIN);

    assign keep_now = (32'(cnt_reg) >= 32'(KEEP_LO)) && (32'(cnt_reg) < 32'(KEEP_HI));

    assign rec_prod = PROD_W'({sum_reg, 4'b0000}) * PROD_W'(REC_M);

    assign mean   = filt_reg[13:4];
    assign diff_w = $signed({1'b0, mean}) - $signed({1'b0, low_end_reg});
    assign span_w = $signed({1'b0, end_angle_reg}) - $signed({1'b0, start_angle_reg});
    assign neg_w  = prod_reg[19] ^ den_reg[SW];

    assign div_start = (state_reg == S_AGO);

    assign div_dividend = prod_reg[19] ? 20'(-prod_reg) : 20'(prod_reg);
    assign div_divisor  = den_reg[SW] ? tmfa_pkg::DVS_W'(-den_reg)
                                      : tmfa_pkg::DVS_W'(den_reg);

    assign quo_signed = neg_w ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        filt_next  = filt_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        rerr_next  = rerr_reg;
        ang_next   = ang_reg;
        case (state_reg)
            S_COLLECT:
            begin
                if (in_xfer)
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        sum_next   = '0;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                if (keep_now)
                begin
                    sum_next = sum_reg + SUM_W'(cell_val[0]);
                end
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next = '0;
                    if (KEPT > 0)
                    begin
                        state_next = S_FILT;
                    end
                    else
                    begin
                        filt_next  = '0;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FILT:
            begin
                filt_next  = rec_prod[REC_SH +: tmfa_pkg::FILT_W];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = 20'(diff_w) * 20'(span_w);
                den_next  = $signed({1'b0, high_end_reg}) - $signed({1'b0, low_end_reg});
                if (low_end_reg == high_end_reg)
                begin
                    rerr_next  = 1'b1;
                    ang_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    rerr_next  = 1'b0;
                    state_next = S_AGO;
                end
            end
            S_AGO:
            begin
                state_next = S_AWAIT;
            end
            S_AWAIT:
            begin
                if (div_stat.done)
                begin
                    ang_next   = quo_signed + $signed({13'b0, start_angle_reg});
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    assign sat_hi = ang_reg > 21'sd32767;
    assign sat_lo = ang_reg < -21'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_COLLECT;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            low_end_reg     <= '0;
            high_end_reg    <= 10'd1023;
            start_angle_reg <= '0;
            end_angle_reg   <= 8'd180;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                case (wr_index)
                    tmfa_pkg::CFG_LOW_END:     low_end_reg     <= wr_data;
                    tmfa_pkg::CFG_HIGH_END:    high_end_reg    <= wr_data;
                    tmfa_pkg::CFG_START_ANGLE: start_angle_reg <= wr_data[7:0];
                    tmfa_pkg::CFG_END_ANGLE:   end_angle_reg   <= wr_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        filt_reg <= filt_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
        rerr_reg <= rerr_next;
        ang_reg  <= ang_next;
        if (state_reg == S_OUT && out_free)
        begin
            filtered_value_reg  <= filt_reg;
            range_error_reg     <= rerr_reg;
            angle_saturated_reg <= sat_hi || sat_lo;
            if (sat_hi)
            begin
                angle_reg <= 16'sh7FFF;
            end
            else if (sat_lo)
            begin
                angle_reg <= -16'sh8000;
            end
            else
            begin
                angle_reg <= ang_reg[tmfa_pkg::ANGLE_W-1:0];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_value  = filtered_value_reg;
    assign angle           = angle_reg;
    assign range_error     = range_error_reg;
    assign angle_saturated = angle_saturated_reg;

`ifndef SYNTH
    // While collecting, the chain holds exactly as many samples as have been counted.
    a_chain_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COLLECT) |-> ($countones(cell_full) == 32'(cnt_reg)))
        else $error("sorting chain occupancy disagrees with the sample count");

    // The last transfer of a set starts the drain.
    a_set_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && cnt_reg == LAST_IDX) |=> (state_reg == S_DRAIN))
        else $error("completed set did not start draining");

    // The divider is only started when it is idle.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A new result only appears after the output stage.
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result appeared outside the output stage");

    // An empty calibrated range never reports a clipped angle.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(range_error_reg && angle_saturated_reg))
        else $error("range error and saturation reported together");
`endif

endmodule

`default_nettype wire

### rtl/tmfa_cell.sv
// One cell of the sorting chain: holds one sample and an occupied flag.
// Uses tmfa_pkg for the sample width and the control struct.
`default_nettype none

module tmfa_cell
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tmfa_pkg::cell_ctrl_t             ctrl,
    input  wire logic [tmfa_pkg::SAMPLE_W-1:0]    sample_in,
    input  wire logic                             left_gt,
    input  wire logic [tmfa_pkg::SAMPLE_W-1:0]    left_val,
    input  wire logic                             left_full,
    input  wire logic [tmfa_pkg::SAMPLE_W-1:0]    right_val,
    input  wire logic                             right_full,
    output      logic [tmfa_pkg::SAMPLE_W-1:0]    val,
    output      logic                             full,
    output      logic                             gt
);

    logic [tmfa_pkg::SAMPLE_W-1:0] val_reg;
    logic [tmfa_pkg::SAMPLE_W-1:0] val_next;
    logic                          full_reg;
    logic                          full_next;

    // The new sample belongs at or before this cell when the cell is empty or holds more.
    assign gt = !full_reg || (sample_in < val_reg);

    always_comb
    begin
        val_next  = val_reg;
        full_next = full_reg;
        if (ctrl.drain)
        begin
            val_next  = right_val;
            full_next = right_full;
        end
        else if (ctrl.insert && gt)
        begin
            if (left_gt)
            begin
                val_next  = left_val;
                full_next = left_full;
            end
            else
            begin
                val_next  = sample_in;
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val  = val_reg;
    assign full = full_reg;

endmodule

`default_nettype wire

### rtl/tmfa_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Uses tmfa_pkg for the operand widths and the status struct.
`default_nettype none

module tmfa_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tmfa_pkg::DVD_W-1:0]    dividend,
    input  wire logic [tmfa_pkg::DVS_W-1:0]    divisor,
    output      tmfa_pkg::div_stat_t           stat,
    output      logic [tmfa_pkg::DVD_W-1:0]    quotient
);

    localparam logic [tmfa_pkg::DIV_CNT_W-1:0] LAST_STEP =
        tmfa_pkg::DIV_CNT_W'(tmfa_pkg::DVD_W - 1);

    logic                              busy_reg;
    logic                              done_reg;
    logic [tmfa_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [tmfa_pkg::DVD_W-1:0]        quo_reg;
    logic [tmfa_pkg::DVD_W-1:0]        quo_next;
    logic [tmfa_pkg::DVS_W-1:0]        rem_reg;
    logic [tmfa_pkg::DVS_W-1:0]        rem_next;
    logic [tmfa_pkg::DVS_W-1:0]        dvs_reg;
    logic [tmfa_pkg::DVS_W:0]          trial;
    logic [tmfa_pkg::DVS_W:0]          diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[tmfa_pkg::DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = diff[tmfa_pkg::DVS_W-1:0];
            quo_next = {quo_reg[tmfa_pkg::DVD_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[tmfa_pkg::DVS_W-1:0];
            quo_next = {quo_reg[tmfa_pkg::DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire
